[hdl/sob_pkg.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, types and constants for the RGB Sobel unit.
// ----------------------------------------------------------------------------
package sob_pkg;

    localparam int ROOT_BITS  = 8;
    localparam int SUM_W      = 21;      // gx^2 + gy^2 <= 2080800
    localparam int GRAD_W     = 12;      // |gx|, |gy| <= 1020
    localparam int MAX_HEIGHT = 2048;
    localparam int CLAMP      = 255;

    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [ROOT_BITS-1:0] root_t;

endpackage

[hdl/sobel_edge_magnitude_rgb_unit.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Streaming 3x3 Sobel filter giving per-channel rounded gradient magnitude.
// ----------------------------------------------------------------------------
// Feed each frame as width*height pixels in raster order followed by width+1
// drain requests; the result for a pixel leaves width+1 requests after it
// entered, with row_end and frame_end marking row and frame boundaries.
// One request is in flight at a time. A result item goes from accept to the
// result register via line store read, window and gradient, squares, nine
// square root chain stages and a wait for a free output register; others
// return to idle after the gradient step. Line stores need no clearing after
// reset; border taps are masked. Configuration writes are taken any time.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out,
    output logic        m_row_end,
    output logic        m_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = (CW + 1 > 12) ? CW + 1 : 12;
    localparam int GW = sob_pkg::GRAD_W;

    localparam logic       REG_WIDTH  = 1'b0;
    localparam logic       REG_HEIGHT = 1'b1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_GRAD = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_ROOT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [3:0] ROOT_LAST = 4'd8;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  cnt_reg;
    logic [11:0] width_reg, height_reg;
    logic [CW-1:0] col_reg;
    logic [11:0] row_reg;
    logic [23:0] pix_reg;
    logic [23:0] win_reg [3][3];
    logic        prod_reg, rend_reg, fend_reg;
    logic signed [GW-1:0] gx_reg [3];
    logic signed [GW-1:0] gy_reg [3];
    sob_pkg::sum_t  sum_reg [3];
    sob_pkg::root_t root [3];
    logic        out_valid_reg;
    logic [7:0]  out_ch_reg [3];
    logic        out_rend_reg, out_fend_reg;

    logic [23:0] top_rd, mid_rd, pix_eff;
    logic [LW-1:0] w_eff, ocol, col_ext;
    logic [11:0] h_eff;
    logic signed [13:0] orow, h_s;
    logic        produce, mr0, mr2, mc0, mc2;
    logic [23:0] nwin [3][3];
    logic signed [GW-1:0] gx [3];
    logic signed [GW-1:0] gy [3];
    logic        out_free;

    // effective frame size
    always_comb begin
        if (width_reg == 12'd0) begin
            w_eff = LW'(1);
        end else if (LW'(width_reg) > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = LW'(width_reg);
        end
        if (height_reg == 12'd0) begin
            h_eff = 12'd1;
        end else if (height_reg > 12'(sob_pkg::MAX_HEIGHT)) begin
            h_eff = 12'(sob_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // line stores
    sob_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_GRAD),
        .wr_addr (col_reg),
        .wr_data (mid_rd),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (col_reg),
        .rd_data (top_rd)
    );

    sob_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_lower (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_GRAD),
        .wr_addr (col_reg),
        .wr_data (pix_eff),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (col_reg),
        .rd_data (mid_rd)
    );

    // window shift, output position and border masks
    always_comb begin
        pix_eff = (row_reg >= h_eff) ? 24'd0 : pix_reg;
        for (int r = 0; r < 3; r++) begin
            nwin[r][0] = win_reg[r][1];
            nwin[r][1] = win_reg[r][2];
        end
        nwin[0][2] = top_rd;
        nwin[1][2] = mid_rd;
        nwin[2][2] = pix_eff;

        col_ext = LW'(col_reg);
        h_s     = 14'(h_eff);
        if (col_reg == '0) begin
            ocol = w_eff - LW'(1);
            orow = $signed(14'(row_reg)) - 14'sd2;
        end else begin
            ocol = col_ext - LW'(1);
            orow = $signed(14'(row_reg)) - 14'sd1;
        end
        produce = (orow >= 14'sd0) && (orow < h_s) && (ocol < w_eff);
        mr0 = orow >= 14'sd1;
        mr2 = (orow + 14'sd1) < h_s;
        mc0 = ocol >= LW'(1);
        mc2 = (ocol + LW'(1)) < w_eff;
    end

    // masked Sobel gradients per channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic signed [GW-1:0] v [3][3];
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    v[r][c] = GW'(nwin[r][c][23-8*ch -: 8]);
                    if ((r == 0 && !mr0) || (r == 2 && !mr2) ||
                        (c == 0 && !mc0) || (c == 2 && !mc2)) begin
                        v[r][c] = '0;
                    end
                end
            end
            gx[ch] = (v[0][2] + (v[1][2] <<< 1) + v[2][2])
                   - (v[0][0] + (v[1][0] <<< 1) + v[2][0]);
            gy[ch] = (v[2][0] + (v[2][1] <<< 1) + v[2][2])
                   - (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
        end
    end

    // root chains, one per channel
    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_chan
            sob_root_chain u_chain (
                .aclk     (aclk),
                .sum_in   (sum_reg[g]),
                .root_out (root[g])
            );
        end
    endgenerate

    assign out_free = !out_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_READ;
            ST_READ: state_next = ST_GRAD;
            ST_GRAD: state_next = produce ? ST_SQ : ST_IDLE;
            ST_SQ:   state_next = ST_ROOT;
            ST_ROOT: if (cnt_reg == ROOT_LAST) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            width_reg     <= 12'd640;
            height_reg    <= 12'd480;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                if (cfg_index == REG_WIDTH) begin
                    width_reg <= cfg_data;
                end else if (cfg_index == REG_HEIGHT) begin
                    height_reg <= cfg_data;
                end
            end
            cnt_reg <= (state_reg == ST_ROOT) ? cnt_reg + 4'd1 : 4'd0;
            if (state_reg == ST_GRAD) begin
                win_reg <= nwin;
                if (row_reg >= h_eff + 12'd1) begin
                    row_reg <= '0;
                    col_reg <= '0;
                end else if (col_ext + LW'(1) >= w_eff) begin
                    col_reg <= '0;
                    row_reg <= row_reg + 12'd1;
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            pix_reg <= {s_red_in, s_green_in, s_blue_in};
        end
        if (state_reg == ST_GRAD) begin
            prod_reg <= produce;
            rend_reg <= (ocol == w_eff - LW'(1));
            fend_reg <= (ocol == w_eff - LW'(1)) && (orow == h_s - 14'sd1);
            gx_reg   <= gx;
            gy_reg   <= gy;
        end
        if (state_reg == ST_SQ) begin
            for (int ch = 0; ch < 3; ch++) begin
                sum_reg[ch] <= sob_pkg::SUM_W'(gx_reg[ch] * gx_reg[ch])
                             + sob_pkg::SUM_W'(gy_reg[ch] * gy_reg[ch]);
            end
        end
        if (state_reg == ST_OUT && out_free && prod_reg) begin
            out_ch_reg   <= root;
            out_rend_reg <= rend_reg;
            out_fend_reg <= fend_reg;
        end
    end

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = out_valid_reg;
    assign m_red_out   = out_ch_reg[0];
    assign m_green_out = out_ch_reg[1];
    assign m_blue_out  = out_ch_reg[2];
    assign m_row_end   = out_rend_reg;
    assign m_frame_end = out_fend_reg;

endmodule

[hdl/sob_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sob_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/sob_root_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// Decides one result bit and hands the partial root to the next cell.
// ----------------------------------------------------------------------------
module sob_root_cell #(
    parameter int BIT = 7
) (
    input  logic          aclk,
    input  sob_pkg::sum_t  s_in,
    input  sob_pkg::root_t r_in,
    output sob_pkg::sum_t  s_out,
    output sob_pkg::root_t r_out
);

    sob_pkg::root_t          trial;
    logic [2*sob_pkg::ROOT_BITS-1:0] trial_sq;

    // try setting this bit, keep it if the square still fits
    always_comb begin
        trial    = r_in | (sob_pkg::root_t'(1) << BIT);
        trial_sq = trial * trial;
    end

    always_ff @(posedge aclk) begin
        s_out <= s_in;
        r_out <= (sob_pkg::SUM_W'(trial_sq) <= s_in) ? trial : r_in;
    end

endmodule

[hdl/sob_root_chain.sv]
// ----------------------------------------------------------------------------
// Rounded square root chain
// Eight bit cells followed by a rounding and clamping stage.
// ----------------------------------------------------------------------------
module sob_root_chain (
    input  logic          aclk,
    input  sob_pkg::sum_t  sum_in,
    output sob_pkg::root_t root_out
);

    localparam int NB = sob_pkg::ROOT_BITS;

    sob_pkg::sum_t  s_tap [NB+1];
    sob_pkg::root_t r_tap [NB+1];
    logic [2*NB:0]  rr_plus;

    assign s_tap[0] = sum_in;
    assign r_tap[0] = '0;

    genvar k;
    generate
        for (k = 0; k < NB; k++) begin : g_cell
            sob_root_cell #(.BIT(NB-1-k)) u_cell (
                .aclk  (aclk),
                .s_in  (s_tap[k]),
                .r_in  (r_tap[k]),
                .s_out (s_tap[k+1]),
                .r_out (r_tap[k+1])
            );
        end
    endgenerate

    // round to nearest: r*r + r is the midpoint limit
    assign rr_plus = (2*NB+1)'(r_tap[NB] * r_tap[NB]) + (2*NB+1)'(r_tap[NB]);

    always_ff @(posedge aclk) begin
        if (s_tap[NB] > sob_pkg::SUM_W'(sob_pkg::CLAMP * sob_pkg::CLAMP + sob_pkg::CLAMP)) begin
            root_out <= sob_pkg::root_t'(sob_pkg::CLAMP);
        end else if (s_tap[NB] > sob_pkg::SUM_W'(rr_plus)) begin
            root_out <= r_tap[NB] + sob_pkg::root_t'(1);
        end else begin
            root_out <= r_tap[NB];
        end
    end

endmodule
